// ===== design/i2cms_pkg.sv =====
// Shared types and phase codes for the I2C master byte sequencer.
package i2cms_pkg;

  localparam int unsigned PHASE_W = 5;
  localparam int unsigned CFG_W   = 16;

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_STOP  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  localparam logic [PHASE_W-1:0] PH_IDLE       = 5'd0;
  localparam logic [PHASE_W-1:0] PH_ST_SCL_HI  = 5'd1;
  localparam logic [PHASE_W-1:0] PH_ST_SDA_LO  = 5'd2;
  localparam logic [PHASE_W-1:0] PH_ST_SCL_LO  = 5'd3;
  localparam logic [PHASE_W-1:0] PH_ST_END     = 5'd4;
  localparam logic [PHASE_W-1:0] PH_SP_SCL_HI  = 5'd5;
  localparam logic [PHASE_W-1:0] PH_SP_SDA_HI  = 5'd6;
  localparam logic [PHASE_W-1:0] PH_SP_END     = 5'd7;
  localparam logic [PHASE_W-1:0] PH_WR_BIT     = 5'd8;
  localparam logic [PHASE_W-1:0] PH_WR_SCL_HI  = 5'd9;
  localparam logic [PHASE_W-1:0] PH_WR_SCL_LO  = 5'd10;
  localparam logic [PHASE_W-1:0] PH_WR_REL     = 5'd11;
  localparam logic [PHASE_W-1:0] PH_WR_ACK_HI  = 5'd12;
  localparam logic [PHASE_W-1:0] PH_WR_ACK_SMP = 5'd13;
  localparam logic [PHASE_W-1:0] PH_WR_END     = 5'd14;
  localparam logic [PHASE_W-1:0] PH_RD_SCL_HI  = 5'd15;
  localparam logic [PHASE_W-1:0] PH_RD_SMP     = 5'd16;
  localparam logic [PHASE_W-1:0] PH_RD_ACK_HI  = 5'd17;
  localparam logic [PHASE_W-1:0] PH_RD_ACK_LO  = 5'd18;
  localparam logic [PHASE_W-1:0] PH_RD_REL     = 5'd19;

  typedef struct packed {
    logic       cmd_valid;
    logic [1:0] operation;
    logic [7:0] write_data;
    logic       send_ack;
    logic       sda_in;
  } item_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       ack_level;
  } res_t;

  function automatic logic is_end_phase(input logic [PHASE_W-1:0] p);
    return (p == PH_ST_END) || (p == PH_SP_END) || (p == PH_WR_END);
  endfunction

endpackage

// ===== design/i2cms_in_stage.sv =====
// Input register stage: captures one item and holds it until the core takes it.
module i2cms_in_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  i2cms_pkg::item_t in_item,
  input  logic             take,
  output logic             s1_valid,
  output i2cms_pkg::item_t s1_item
);
  import i2cms_pkg::*;

  logic  valid_r;
  item_t item_r;
  logic  load;

  assign in_stall = valid_r && !take;
  assign load     = in_valid && !in_stall;
  assign s1_valid = valid_r;
  assign s1_item  = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (take) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= in_item;
    end
  end

endmodule

// ===== design/i2cms_core.sv =====
// Phase sequencer: state registers and the one-tick step logic.
module i2cms_core #(
  parameter int unsigned DELAY_COUNT_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step,
  input  i2cms_pkg::item_t              item,
  input  logic [i2cms_pkg::CFG_W-1:0]   delay_ticks,
  output i2cms_pkg::res_t               res
);
  import i2cms_pkg::*;

  localparam int unsigned DW = DELAY_COUNT_WIDTH;

  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [2:0]         bit_r, bit_nxt;
  logic [7:0]         shift_r, shift_nxt;
  logic [DW-1:0]      dcnt_r, dcnt_nxt;
  logic               scl_r, scl_nxt;
  logic               sda_r, sda_nxt;
  logic               ack_r, ack_nxt;
  logic               choice_r, choice_nxt;
  logic [7:0]         latch_r, latch_nxt;
  logic               done;

  logic [CFG_W-1:0]   hold_m1;
  logic [31:0]        hold_ext;
  logic [DW-1:0]      load_val;
  logic [DW-1:0]      dcnt_dec;
  logic               run_hold;

  assign hold_m1  = (delay_ticks == '0) ? '0 : delay_ticks - 1'b1;
  assign hold_ext = {{(32-CFG_W){1'b0}}, hold_m1};
  assign load_val = hold_ext[DW-1:0];
  assign dcnt_dec = dcnt_r - 1'b1;

  always_comb begin
    phase_nxt  = phase_r;
    bit_nxt    = bit_r;
    shift_nxt  = shift_r;
    dcnt_nxt   = dcnt_r;
    scl_nxt    = scl_r;
    sda_nxt    = sda_r;
    ack_nxt    = ack_r;
    choice_nxt = choice_r;
    latch_nxt  = latch_r;
    done       = 1'b0;
    run_hold   = 1'b0;
    if (phase_r == PH_IDLE) begin
      if (item.cmd_valid) begin
        bit_nxt  = 3'd7;
        dcnt_nxt = load_val;
        unique case (item.operation)
          OP_START: begin
            sda_nxt   = 1'b1;
            phase_nxt = PH_ST_SCL_HI;
          end
          OP_STOP: begin
            sda_nxt   = 1'b0;
            phase_nxt = PH_SP_SCL_HI;
          end
          OP_WRITE: begin
            shift_nxt = item.write_data;
            sda_nxt   = item.write_data[7];
            phase_nxt = PH_WR_SCL_HI;
          end
          default: begin
            shift_nxt  = 8'd0;
            choice_nxt = item.send_ack;
            sda_nxt    = 1'b1;
            phase_nxt  = PH_RD_SCL_HI;
          end
        endcase
      end
    end else if (dcnt_r != '0) begin
      dcnt_nxt = dcnt_dec;
      if ((dcnt_dec == '0) && is_end_phase(phase_r)) begin
        phase_nxt = PH_IDLE;
        done      = 1'b1;
      end
    end else if (is_end_phase(phase_r)) begin
      phase_nxt = PH_IDLE;
      done      = 1'b1;
    end else begin
      run_hold = 1'b1;
      unique case (phase_r)
        PH_ST_SCL_HI: begin scl_nxt = 1'b1; phase_nxt = PH_ST_SDA_LO; end
        PH_ST_SDA_LO: begin sda_nxt = 1'b0; phase_nxt = PH_ST_SCL_LO; end
        PH_ST_SCL_LO: begin scl_nxt = 1'b0; phase_nxt = PH_ST_END; end
        PH_SP_SCL_HI: begin scl_nxt = 1'b1; phase_nxt = PH_SP_SDA_HI; end
        PH_SP_SDA_HI: begin sda_nxt = 1'b1; phase_nxt = PH_SP_END; end
        PH_WR_BIT: begin
          sda_nxt   = shift_r[bit_r];
          phase_nxt = PH_WR_SCL_HI;
        end
        PH_WR_SCL_HI: begin scl_nxt = 1'b1; phase_nxt = PH_WR_SCL_LO; end
        PH_WR_SCL_LO: begin
          scl_nxt = 1'b0;
          if (bit_r == 3'd0) begin
            phase_nxt = PH_WR_REL;
          end else begin
            bit_nxt   = bit_r - 3'd1;
            phase_nxt = PH_WR_BIT;
          end
        end
        PH_WR_REL:    begin sda_nxt = 1'b1; phase_nxt = PH_WR_ACK_HI; end
        PH_WR_ACK_HI: begin scl_nxt = 1'b1; phase_nxt = PH_WR_ACK_SMP; end
        PH_WR_ACK_SMP: begin
          ack_nxt   = item.sda_in;
          scl_nxt   = 1'b0;
          phase_nxt = PH_WR_END;
        end
        PH_RD_SCL_HI: begin scl_nxt = 1'b1; phase_nxt = PH_RD_SMP; end
        PH_RD_SMP: begin
          if (item.sda_in) begin
            shift_nxt[bit_r] = 1'b1;
          end
          scl_nxt = 1'b0;
          if (bit_r == 3'd0) begin
            sda_nxt   = !choice_r;
            phase_nxt = PH_RD_ACK_HI;
          end else begin
            bit_nxt   = bit_r - 3'd1;
            phase_nxt = PH_RD_SCL_HI;
          end
        end
        PH_RD_ACK_HI: begin scl_nxt = 1'b1; phase_nxt = PH_RD_ACK_LO; end
        PH_RD_ACK_LO: begin scl_nxt = 1'b0; phase_nxt = PH_RD_REL; end
        PH_RD_REL: begin
          run_hold  = 1'b0;
          sda_nxt   = 1'b1;
          latch_nxt = shift_r;
          phase_nxt = PH_IDLE;
          dcnt_nxt  = '0;
          done      = 1'b1;
        end
        default: begin
          run_hold  = 1'b0;
          phase_nxt = PH_IDLE;
          dcnt_nxt  = '0;
          done      = 1'b1;
        end
      endcase
      if (run_hold) begin
        dcnt_nxt = load_val;
        if (is_end_phase(phase_nxt) && (load_val == '0)) begin
          phase_nxt = PH_IDLE;
          done      = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      bit_r    <= 3'd7;
      shift_r  <= 8'd0;
      dcnt_r   <= '0;
      scl_r    <= 1'b1;
      sda_r    <= 1'b1;
      ack_r    <= 1'b0;
      choice_r <= 1'b0;
      latch_r  <= 8'd0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      bit_r    <= bit_nxt;
      shift_r  <= shift_nxt;
      dcnt_r   <= dcnt_nxt;
      scl_r    <= scl_nxt;
      sda_r    <= sda_nxt;
      ack_r    <= ack_nxt;
      choice_r <= choice_nxt;
      latch_r  <= latch_nxt;
    end
  end

  always_comb begin
    res.scl_out   = scl_nxt;
    res.sda_out   = sda_nxt;
    res.busy_res  = (phase_nxt != PH_IDLE);
    res.done_res  = done;
    res.read_data = latch_nxt;
    res.ack_level = ack_nxt;
  end

endmodule

// ===== design/i2cms_out_stage.sv =====
// Result register stage: holds one result until the downstream side takes it.
module i2cms_out_stage (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            load,
  input  i2cms_pkg::res_t res_in,
  output logic            ready,
  output logic            out_valid,
  input  logic            out_stall,
  output i2cms_pkg::res_t res_out
);
  import i2cms_pkg::*;

  logic valid_r;
  res_t res_r;

  assign ready     = !valid_r || !out_stall;
  assign out_valid = valid_r;
  assign res_out   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && load) begin
      res_r <= res_in;
    end
  end

endmodule

// ===== design/i2c_master_byte_sequencer_top.sv =====
// Top level of the I2C master byte sequencer: input stage, sequencer core, result stage.
//
//   channel | handshake          | payload
//   in_     | in_valid/in_stall  | cmd_valid, operation, write_data, send_ack, sda_in
//   out_    | out_valid/out_stall| scl_out, sda_out, busy_res, done_res, read_data, ack_level
//   cfg_    | cfg_valid/cfg_ready| delay_ticks
//
// One item in, one result out; an item is taken every cycle when the output is not stalled.
// Each item passes the input register, then the step logic into the result register.
// Synchronous active-low reset; the core's pin registers reset released high, delay_ticks resets to 5.
// A stall on the output backs up into the input stage after one held item.
module i2c_master_byte_sequencer_top #(
  parameter int unsigned DELAY_COUNT_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_cmd_valid,
  input  logic [1:0]  in_operation,
  input  logic [7:0]  in_write_data,
  input  logic        in_send_ack,
  input  logic        in_sda_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_scl_out,
  output logic        out_sda_out,
  output logic        out_busy_res,
  output logic        out_done_res,
  output logic [7:0]  out_read_data,
  output logic        out_ack_level,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_delay_ticks
);
  import i2cms_pkg::*;

  item_t            in_item;
  item_t            s1_item;
  logic             s1_valid;
  logic             out_ready;
  logic             step;
  res_t             core_res;
  res_t             out_res;
  logic [CFG_W-1:0] delay_ticks_r;

  assign in_item.cmd_valid  = in_cmd_valid;
  assign in_item.operation  = in_operation;
  assign in_item.write_data = in_write_data;
  assign in_item.send_ack   = in_send_ack;
  assign in_item.sda_in     = in_sda_in;

  assign step      = s1_valid && out_ready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_ticks_r <= 16'd5;
    end else if (cfg_valid) begin
      delay_ticks_r <= cfg_delay_ticks;
    end
  end

  i2cms_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .take     (out_ready),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  i2cms_core #(
    .DELAY_COUNT_WIDTH (DELAY_COUNT_WIDTH)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .item        (s1_item),
    .delay_ticks (delay_ticks_r),
    .res         (core_res)
  );

  i2cms_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (s1_valid),
    .res_in    (core_res),
    .ready     (out_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res_out   (out_res)
  );

  assign out_scl_out   = out_res.scl_out;
  assign out_sda_out   = out_res.sda_out;
  assign out_busy_res  = out_res.busy_res;
  assign out_done_res  = out_res.done_res;
  assign out_read_data = out_res.read_data;
  assign out_ack_level = out_res.ack_level;

endmodule

// ===== sim/testbench.sv =====
// Testbench for the I2C master byte sequencer: per-tick pin prediction checked against each result.
module testbench;
  import i2cms_pkg::*;

  localparam int WATCHDOG_LIMIT = 10000;
  localparam int RANDOM_TICKS   = 300;
  localparam int SDA_LOW        = 0;
  localparam int SDA_HIGH       = 1;
  localparam int SDA_RANDOM     = 2;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  item_t            in_tick = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic             out_scl_out;
  logic             out_sda_out;
  logic             out_busy_res;
  logic             out_done_res;
  logic [7:0]       out_read_data;
  logic             out_ack_level;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_delay_ticks = '0;

  // predicted sequencer state
  logic [CFG_W-1:0]   delay_cfg = 16'd5;
  logic [PHASE_W-1:0] seq_phase = PH_IDLE;
  logic [2:0]         bit_pos = 3'd7;
  logic [7:0]         shift_reg = '0;
  logic [15:0]        hold_count = '0;
  logic               scl_q = 1'b1;
  logic               sda_q = 1'b1;
  logic               ack_q = 1'b0;
  logic               ack_sel = 1'b0;
  logic [7:0]         read_byte = '0;

  res_t pending_pins[$];
  int   mismatches = 0;
  int   ticks_sent = 0;
  int   receiver_hold = 0;
  int   quiet_cycles = 0;
  bit   idle_on = 1'b1;

  i2c_master_byte_sequencer_top dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_cmd_valid   (in_tick.cmd_valid),
    .in_operation   (in_tick.operation),
    .in_write_data  (in_tick.write_data),
    .in_send_ack    (in_tick.send_ack),
    .in_sda_in      (in_tick.sda_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_scl_out    (out_scl_out),
    .out_sda_out    (out_sda_out),
    .out_busy_res   (out_busy_res),
    .out_done_res   (out_done_res),
    .out_read_data  (out_read_data),
    .out_ack_level  (out_ack_level),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_delay_ticks(cfg_delay_ticks)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return int'($urandom_range(1, 3));
    return int'($urandom_range(8, 40));
  endfunction

  function automatic logic [15:0] hold_load();
    return (delay_cfg == '0) ? 16'd0 : delay_cfg - 1'b1;
  endfunction

  function automatic bit phase_is_final(input logic [PHASE_W-1:0] p);
    return (p == PH_ST_END) || (p == PH_SP_END) || (p == PH_WR_END);
  endfunction

  task automatic run_step(input logic sda, output logic fin);
    logic load;
    load = 1'b1;
    fin = 1'b0;
    case (seq_phase)
      PH_ST_SCL_HI: begin scl_q = 1'b1; seq_phase = PH_ST_SDA_LO; end
      PH_ST_SDA_LO: begin sda_q = 1'b0; seq_phase = PH_ST_SCL_LO; end
      PH_ST_SCL_LO: begin scl_q = 1'b0; seq_phase = PH_ST_END; end
      PH_SP_SCL_HI: begin scl_q = 1'b1; seq_phase = PH_SP_SDA_HI; end
      PH_SP_SDA_HI: begin sda_q = 1'b1; seq_phase = PH_SP_END; end
      PH_WR_BIT: begin sda_q = shift_reg[bit_pos]; seq_phase = PH_WR_SCL_HI; end
      PH_WR_SCL_HI: begin scl_q = 1'b1; seq_phase = PH_WR_SCL_LO; end
      PH_WR_SCL_LO: begin
        scl_q = 1'b0;
        if (bit_pos == 3'd0) begin
          seq_phase = PH_WR_REL;
        end else begin
          bit_pos = bit_pos - 1'b1;
          seq_phase = PH_WR_BIT;
        end
      end
      PH_WR_REL: begin sda_q = 1'b1; seq_phase = PH_WR_ACK_HI; end
      PH_WR_ACK_HI: begin scl_q = 1'b1; seq_phase = PH_WR_ACK_SMP; end
      PH_WR_ACK_SMP: begin ack_q = sda; scl_q = 1'b0; seq_phase = PH_WR_END; end
      PH_RD_SCL_HI: begin scl_q = 1'b1; seq_phase = PH_RD_SMP; end
      PH_RD_SMP: begin
        if (sda) shift_reg[bit_pos] = 1'b1;
        scl_q = 1'b0;
        if (bit_pos == 3'd0) begin
          sda_q = !ack_sel;
          seq_phase = PH_RD_ACK_HI;
        end else begin
          bit_pos = bit_pos - 1'b1;
          seq_phase = PH_RD_SCL_HI;
        end
      end
      PH_RD_ACK_HI: begin scl_q = 1'b1; seq_phase = PH_RD_ACK_LO; end
      PH_RD_ACK_LO: begin scl_q = 1'b0; seq_phase = PH_RD_REL; end
      PH_RD_REL: begin
        sda_q = 1'b1;
        read_byte = shift_reg;
        seq_phase = PH_IDLE;
        hold_count = '0;
        fin = 1'b1;
        load = 1'b0;
      end
      default: begin
        seq_phase = PH_IDLE;
        hold_count = '0;
        fin = 1'b1;
        load = 1'b0;
      end
    endcase
    if (load) begin
      hold_count = hold_load();
      if (phase_is_final(seq_phase) && hold_count == '0) begin
        seq_phase = PH_IDLE;
        fin = 1'b1;
      end
    end
  endtask

  task automatic tick_sequencer(input item_t t, output res_t want);
    logic fin;
    fin = 1'b0;
    if (seq_phase == PH_IDLE) begin
      if (t.cmd_valid) begin
        bit_pos = 3'd7;
        case (t.operation)
          OP_START: begin sda_q = 1'b1; seq_phase = PH_ST_SCL_HI; hold_count = hold_load(); end
          OP_STOP: begin sda_q = 1'b0; seq_phase = PH_SP_SCL_HI; hold_count = hold_load(); end
          OP_WRITE: begin
            shift_reg = t.write_data;
            seq_phase = PH_WR_BIT;
            run_step(t.sda_in, fin);
          end
          OP_READ: begin
            shift_reg = '0;
            ack_sel = t.send_ack;
            sda_q = 1'b1;
            seq_phase = PH_RD_SCL_HI;
            hold_count = hold_load();
          end
        endcase
      end
    end else if (hold_count != '0) begin
      hold_count = hold_count - 1'b1;
      if (hold_count == '0 && phase_is_final(seq_phase)) begin
        seq_phase = PH_IDLE;
        fin = 1'b1;
      end
    end else if (phase_is_final(seq_phase)) begin
      seq_phase = PH_IDLE;
      fin = 1'b1;
    end else begin
      run_step(t.sda_in, fin);
    end
    want.scl_out   = scl_q;
    want.sda_out   = sda_q;
    want.busy_res  = (seq_phase != PH_IDLE);
    want.done_res  = fin;
    want.read_data = read_byte;
    want.ack_level = ack_q;
  endtask

  function automatic item_t random_tick(input int sda_sel);
    item_t t;
    t.cmd_valid  = 1'($urandom_range(0, 1));
    t.operation  = 2'($urandom_range(0, 3));
    t.write_data = 8'($urandom_range(0, 255));
    t.send_ack   = 1'($urandom_range(0, 1));
    t.sda_in     = (sda_sel == SDA_RANDOM) ? 1'($urandom_range(0, 1)) : (sda_sel == SDA_HIGH);
    return t;
  endfunction

  task automatic send_item(input item_t t);
    res_t want;
    int   gap;
    in_valid <= 1'b1;
    in_tick  <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tick_sequencer(t, want);
    pending_pins.push_back(want);
    ticks_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic run_command(input logic [1:0] op, input logic [7:0] data, input logic ack,
                             input int sda_sel);
    item_t t;
    t = random_tick(sda_sel);
    t.cmd_valid  = 1'b1;
    t.operation  = op;
    t.write_data = data;
    t.send_ack   = ack;
    send_item(t);
    while (seq_phase != PH_IDLE) send_item(random_tick(sda_sel));
  endtask

  task automatic write_delay(input logic [CFG_W-1:0] value);
    in_valid <= 1'b0;
    while (pending_pins.size() != 0) @(posedge clk);
    cfg_valid       <= 1'b1;
    cfg_delay_ticks <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    delay_cfg = value;
    @(posedge clk);
  endtask

  function automatic logic [CFG_W-1:0] pick_delay();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 16'd1;
    if (r < 65) return 16'd2;
    if (r < 80) return 16'd3;
    if (r < 88) return 16'd0;
    return 16'($urandom_range(4, 12));
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    if (mismatches < 40)
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  task automatic compare_field(input string what, input logic [7:0] got,
                               input logic [7:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  always @(posedge clk) begin : pin_checker
    res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_pins.size() == 0) begin
        report_mismatch("result with no item pending", 8'h00, 8'h00);
      end else begin
        want = pending_pins.pop_front();
        compare_field("scl_out", 8'(out_scl_out), 8'(want.scl_out));
        compare_field("sda_out", 8'(out_sda_out), 8'(want.sda_out));
        compare_field("busy_res", 8'(out_busy_res), 8'(want.busy_res));
        compare_field("done_res", 8'(out_done_res), 8'(want.done_res));
        compare_field("read_data", out_read_data, want.read_data);
        compare_field("ack_level", 8'(out_ack_level), 8'(want.ack_level));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin : receiver
    int n;
    while (!rst_n) @(posedge clk);
    forever begin
      n = 0;
      if (receiver_hold > 0) begin
        n = receiver_hold;
        receiver_hold = 0;
      end else if (idle_on && $urandom_range(0, 2) == 0) begin
        n = pick_gap();
      end
      out_stall <= (n > 0);
      repeat ((n > 0) ? n : 1) @(posedge clk);
    end
  end

  task automatic test_reset_state();
    repeat (3) send_item(random_tick(SDA_RANDOM) & ~13'h1000);
    run_command(OP_START, 8'h00, 1'b0, SDA_RANDOM);
    run_command(OP_WRITE, 8'h5A, 1'b0, SDA_RANDOM);
    run_command(OP_STOP, 8'h00, 1'b0, SDA_RANDOM);
  endtask

  task automatic test_every_command();
    write_delay(16'd1);
    run_command(OP_START, 8'h00, 1'b0, SDA_RANDOM);
    run_command(OP_WRITE, 8'h00, 1'b0, SDA_LOW);
    run_command(OP_WRITE, 8'hFF, 1'b1, SDA_HIGH);
    run_command(OP_READ, 8'h00, 1'b1, SDA_HIGH);
    run_command(OP_READ, 8'hFF, 1'b0, SDA_LOW);
    run_command(OP_READ, 8'hA5, 1'b1, SDA_RANDOM);
    run_command(OP_STOP, 8'hFF, 1'b1, SDA_RANDOM);
  endtask

  task automatic test_zero_delay();
    write_delay(16'd0);
    run_command(OP_START, 8'h00, 1'b0, SDA_RANDOM);
    run_command(OP_WRITE, 8'hA5, 1'b0, SDA_RANDOM);
    run_command(OP_READ, 8'h3C, 1'b0, SDA_RANDOM);
    run_command(OP_STOP, 8'h00, 1'b0, SDA_RANDOM);
  endtask

  task automatic test_busy_commands();
    item_t t;
    write_delay(16'd2);
    run_command(OP_WRITE, 8'hC3, 1'b0, SDA_RANDOM);
    t = random_tick(SDA_RANDOM);
    t.cmd_valid = 1'b1;
    t.operation = OP_READ;
    send_item(t);
    while (seq_phase != PH_IDLE) begin
      t = random_tick(SDA_RANDOM);
      t.cmd_valid = 1'b1;
      send_item(t);
    end
  endtask

  task automatic test_backpressure();
    write_delay(16'd2);
    idle_on = 1'b0;
    receiver_hold = 300;
    run_command(OP_WRITE, 8'($urandom_range(0, 255)), 1'b0, SDA_RANDOM);
    run_command(OP_READ, 8'h00, 1'($urandom_range(0, 1)), SDA_RANDOM);
    idle_on = 1'b1;
  endtask

  task automatic test_long_delay();
    idle_on = 1'b0;
    write_delay(16'd24);
    run_command(OP_STOP, 8'h00, 1'b0, SDA_RANDOM);
    idle_on = 1'b1;
    write_delay(16'd5);
  endtask

  task automatic test_random_traffic();
    int start_count;
    int n;
    start_count = ticks_sent;
    while (ticks_sent - start_count < RANDOM_TICKS) begin
      idle_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 3) == 0) write_delay(pick_delay());
      if ($urandom_range(0, 4) != 0) begin
        run_command(OP_START, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                    SDA_RANDOM);
        n = $urandom_range(1, 3);
        repeat (n)
          run_command(2'($urandom_range(OP_WRITE, OP_READ)), 8'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)), SDA_RANDOM);
        if ($urandom_range(0, 5) != 0)
          run_command(OP_STOP, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                      SDA_RANDOM);
      end else begin
        n = $urandom_range(1, 8);
        repeat (n) send_item(random_tick(SDA_RANDOM));
        while (seq_phase != PH_IDLE) send_item(random_tick(SDA_RANDOM));
      end
    end
    idle_on = 1'b1;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_every_command();
    test_zero_delay();
    test_busy_commands();
    test_backpressure();
    test_long_delay();
    test_random_traffic();
    in_valid <= 1'b0;
    while (pending_pins.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (mismatches == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
